// ===== rtl/core/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the Go-Back-N frame receiver.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int SEQ_BITS_DEF = 8;

    localparam logic [7:0] FLAG_BYTE      = 8'h24;   // '$'
    localparam logic [7:0] WINDOW_RST     = 8'd4;

    localparam logic FT_ACK  = 1'b0;
    localparam logic FT_NACK = 1'b1;

    typedef struct packed {
        logic [7:0] seq_num;
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
        logic [7:0] parity_byte;
    } gbn_in_item_t;

    typedef struct packed {
        logic       frame_type;
        logic [7:0] ack_number;
    } gbn_out_item_t;

    // Input register contents as seen by the check stage
    typedef struct packed {
        logic         valid;
        gbn_in_item_t item;
    } gbn_stage_t;

endpackage

// ===== rtl/core/go_back_n_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// go_back_n_frame_receiver
// Go-Back-N receiver: checks byte-serial frames and answers ACK or NACK.
// ----------------------------------------------------------------------------
// One byte item is taken per cycle while in_stall is low. A byte passes an
// input register and is then folded into the frame state; a byte marked as
// frame end loads its ACK/NACK item into the result register when the check
// stage takes it from the input register, and out_valid rises with that load.
// Bytes without the end mark produce nothing. in_stall rises only when an end
// byte sits in the input register while the result register is full and
// stalled downstream. The window size register may be written only while no
// frame byte is in flight; cfg_ready is always high.
module go_back_n_frame_receiver
    import gbn_pkg::*;
#(
    parameter int SEQ_BITS = SEQ_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  gbn_in_item_t  in_item,
    output logic          out_valid,
    input  logic          out_stall,
    output gbn_out_item_t out_item,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_data
);

    gbn_stage_t stage;
    logic       take;

    assign cfg_ready = 1'b1;

    gbn_input_stage u_input
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .stage    (stage),
        .take     (take)
    );

    gbn_frame_check #(
        .SEQ_BITS (SEQ_BITS)
    ) u_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .take      (take),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ===== rtl/core/gbn_input_stage.sv =====
// ----------------------------------------------------------------------------
// gbn_input_stage
// Input register: holds one byte item until the check stage takes it.
// ----------------------------------------------------------------------------
module gbn_input_stage
    import gbn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  gbn_in_item_t in_item,
    output gbn_stage_t   stage,
    input  logic         take
);

    logic         a_valid_reg;
    logic         a_valid_next;
    gbn_in_item_t a_item_reg;
    logic         load;

    assign in_stall = a_valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
        begin
            a_valid_next = 1'b1;
        end
        else if (take)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_item_reg <= in_item;
        end
    end

    assign stage.valid = a_valid_reg;
    assign stage.item  = a_item_reg;

endmodule

// ===== rtl/core/gbn_frame_check.sv =====
// ----------------------------------------------------------------------------
// gbn_frame_check
// Per-byte frame state, end-of-frame checks and the result register.
// ----------------------------------------------------------------------------
module gbn_frame_check
    import gbn_pkg::*;
#(
    parameter int SEQ_BITS = SEQ_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  gbn_stage_t    stage,
    output logic          take,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_data,
    output logic          out_valid,
    input  logic          out_stall,
    output gbn_out_item_t out_item
);

    localparam int CMP_W = (SEQ_BITS > 8) ? SEQ_BITS : 8;

    logic [SEQ_BITS-1:0] exp_seq_reg;
    logic [SEQ_BITS-1:0] exp_seq_next;
    logic [7:0]          par_acc_reg;
    logic [7:0]          par_acc_next;
    logic                start_ok_reg;
    logic                start_ok_next;
    logic [7:0]          win_reg;
    logic                o_valid_reg;
    logic                o_valid_next;
    gbn_out_item_t       o_item_reg;
    gbn_out_item_t       o_item_next;

    logic                out_ready;
    logic                emit;
    logic                first_ok;
    logic [7:0]          inner;
    logic                good;
    logic [SEQ_BITS-1:0] seq_inc;
    logic [CMP_W-1:0]    exp_ext;

    assign out_ready = !o_valid_reg || !out_stall;
    // non-end bytes never need the result register
    assign take      = stage.valid && (!stage.item.frame_end || out_ready);
    assign emit      = take && stage.item.frame_end;

    always_comb
    begin
        first_ok = stage.item.frame_start ? (stage.item.data_byte == FLAG_BYTE)
                                          : start_ok_reg;
        inner    = stage.item.frame_start ? 8'd0 : par_acc_reg;
        good     = first_ok && (stage.item.data_byte == FLAG_BYTE)
                   && (inner == stage.item.parity_byte)
                   && (CMP_W'(stage.item.seq_num) == CMP_W'(exp_seq_reg));
        seq_inc  = exp_seq_reg + SEQ_BITS'(1);

        exp_seq_next  = exp_seq_reg;
        par_acc_next  = par_acc_reg;
        start_ok_next = start_ok_reg;

        if (take)
        begin
            if (!stage.item.frame_end)
            begin
                if (stage.item.frame_start)
                begin
                    start_ok_next = (stage.item.data_byte == FLAG_BYTE);
                    par_acc_next  = 8'd0;
                end
                else
                begin
                    par_acc_next = par_acc_reg ^ stage.item.data_byte;
                end
            end
            else
            begin
                if (good)
                begin
                    if (CMP_W'(seq_inc) == CMP_W'(win_reg))
                    begin
                        exp_seq_next = '0;
                    end
                    else
                    begin
                        exp_seq_next = seq_inc;
                    end
                end
                par_acc_next  = 8'd0;
                start_ok_next = 1'b0;
            end
        end

        exp_ext                = CMP_W'(exp_seq_next);
        o_item_next.frame_type = good ? FT_ACK : FT_NACK;
        o_item_next.ack_number = exp_ext[7:0];

        if (out_ready)
        begin
            o_valid_next = emit;
        end
        else
        begin
            o_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_seq_reg  <= '0;
            par_acc_reg  <= 8'd0;
            start_ok_reg <= 1'b0;
            win_reg      <= WINDOW_RST;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            exp_seq_reg  <= exp_seq_next;
            par_acc_reg  <= par_acc_next;
            start_ok_reg <= start_ok_next;
            o_valid_reg  <= o_valid_next;
            if (cfg_we)
            begin
                win_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            o_item_reg <= o_item_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_item  = o_item_reg;

endmodule

// ===== rtl/core/gbn_checker.sv =====
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks for the Go-Back-N frame receiver.
// ----------------------------------------------------------------------------
module gbn_checker
    import gbn_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  gbn_in_item_t  in_item,
    input  logic          out_valid,
    input  logic          out_stall,
    input  gbn_out_item_t out_item
);

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result item changed while stalled");

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // a fresh result comes from an accepted end byte
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && in_item.frame_end, 2))
        else $error("result without a matching end byte");

endmodule

bind go_back_n_frame_receiver gbn_checker u_gbn_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
